### hw/rtl/mpq_pkg.sv
// Shared types and constants for the multilevel priority run queue.
// Used by mpq_ctrl, mpq_dp and multilevel_priority_run_queue_core; no dependencies.
`default_nettype none

package mpq_pkg;

   // Default parameter values.
   localparam int LEVELS_DEFAULT      = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TASK_BITS_DEFAULT   = 8;

   // Fixed port field widths.
   localparam int TASK_ID_W = 8;
   localparam int LEVEL_W   = 2;
   localparam int STATUS_W  = 2;
   localparam int WAITING_W = 7;

   // Operation codes.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ADDED      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;  // An input transfer happens this cycle.
      logic load;    // The pending result moves into the output register.
   } mpq_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/mpq_ctrl.sv
// Controller for the multilevel priority run queue: sequences accept and finish.
// Depends on mpq_pkg.
`default_nettype none

module mpq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output mpq_pkg::mpq_cmd_type    cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // Input is taken only in idle; the result leaves when the output slot frees.
   always_comb begin
      cmd.accept = req_valid && (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state and output valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/mpq_dp.sv
// Datapath for the multilevel priority run queue: FIFO pointers, task memory,
// bank select, totals and the output register. Depends on mpq_pkg.
`default_nettype none

module mpq_dp #(
   parameter int LEVELS      = mpq_pkg::LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_BITS   = mpq_pkg::TASK_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mpq_pkg::mpq_cmd_type             cmd,
   input  wire logic                             req_operation,
   input  wire logic [mpq_pkg::TASK_ID_W-1:0]    req_task_id,
   input  wire logic [mpq_pkg::LEVEL_W-1:0]      req_level,
   input  wire logic                             req_from_preemption,
   input  wire logic                             req_priority_wrapped,
   output logic [mpq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [mpq_pkg::TASK_ID_W-1:0]         rsp_next_task,
   output logic [mpq_pkg::LEVEL_W-1:0]           rsp_next_level,
   output logic [mpq_pkg::WAITING_W-1:0]         rsp_active_waiting
);

   localparam int LVL_W     = ($clog2(LEVELS) > 0) ? $clog2(LEVELS) : 1;
   localparam int Q_W       = LVL_W + 1;
   localparam int NQ        = 1 << Q_W;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int TOT_W     = $clog2(LEVELS * QUEUE_DEPTH + 1);
   localparam int A_W       = Q_W + PTR_W;
   localparam int MEM_DEPTH = 1 << A_W;

   // Per-FIFO pointers and fill counts, indexed by {bank, level}.
   logic [PTR_W-1:0]  head_ff [NQ];
   logic [PTR_W-1:0]  head_in [NQ];
   logic [PTR_W-1:0]  tail_ff [NQ];
   logic [PTR_W-1:0]  tail_in [NQ];
   logic [FILL_W-1:0] fill_ff [NQ];
   logic [FILL_W-1:0] fill_in [NQ];

   logic             sel_ff;
   logic             sel_in;
   logic [TOT_W-1:0] act_ff;
   logic [TOT_W-1:0] act_in;
   logic [TOT_W-1:0] exp_ff;
   logic [TOT_W-1:0] exp_in;

   // Result of the item in flight.
   logic [mpq_pkg::STATUS_W-1:0] res_status_ff;
   logic [mpq_pkg::STATUS_W-1:0] res_status_in;
   logic [LVL_W-1:0]             res_level_ff;
   logic [LVL_W-1:0]             res_level_in;
   logic [TOT_W-1:0]             res_waiting_ff;
   logic [TOT_W-1:0]             res_waiting_in;

   // Output register.
   logic [mpq_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [mpq_pkg::TASK_ID_W-1:0] rsp_next_task_ff;
   logic [mpq_pkg::LEVEL_W-1:0]   rsp_next_level_ff;
   logic [mpq_pkg::WAITING_W-1:0] rsp_active_waiting_ff;

   // Task memory.
   logic [TASK_BITS-1:0] task_mem [MEM_DEPTH];
   logic [TASK_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [A_W-1:0]       wr_addr;
   logic [TASK_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [A_W-1:0]       rd_addr;

   // Decode helpers.
   logic             to_exp;
   logic [LVL_W-1:0] lvl_sat;
   logic [Q_W-1:0]   add_q;
   logic             add_full;
   logic             swap;
   logic             sel_take;
   logic [TOT_W-1:0] act_sw;
   logic [TOT_W-1:0] exp_sw;
   logic             found;
   logic [LVL_W-1:0] hit_lvl;
   logic [Q_W-1:0]   take_q;

   // Add path: saturate the level and pick the bank.
   always_comb begin
      if (int'(req_level) >= LEVELS) begin
         lvl_sat = LVL_W'(LEVELS - 1);
      end else begin
         lvl_sat = LVL_W'(req_level);
      end
      to_exp   = req_from_preemption && req_priority_wrapped;
      add_q    = {sel_ff ^ to_exp, lvl_sat};
      add_full = (fill_ff[add_q] == FILL_W'(QUEUE_DEPTH));
   end

   // Take path: swap banks when the active one is empty, then find the top level.
   always_comb begin
      swap     = (act_ff == '0);
      sel_take = swap ? ~sel_ff : sel_ff;
      act_sw   = swap ? exp_ff : act_ff;
      exp_sw   = swap ? act_ff : exp_ff;
      found    = 1'b0;
      hit_lvl  = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (fill_ff[{sel_take, LVL_W'(l)}] != '0) begin
            found   = 1'b1;
            hit_lvl = LVL_W'(l);
         end
      end
      take_q = {sel_take, hit_lvl};
   end

   // State update for one accepted item.
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      sel_in         = sel_ff;
      act_in         = act_ff;
      exp_in         = exp_ff;
      res_status_in  = res_status_ff;
      res_level_in   = res_level_ff;
      res_waiting_in = res_waiting_ff;
      wr_en          = 1'b0;
      wr_addr        = {add_q, tail_ff[add_q]};
      wr_data        = TASK_BITS'(req_task_id);
      rd_en          = 1'b0;
      rd_addr        = {take_q, head_ff[take_q]};
      if (cmd.accept) begin
         res_level_in = '0;
         if (req_operation == mpq_pkg::OP_ADD) begin
            if (add_full) begin
               res_status_in = mpq_pkg::STATUS_DROPPED;
            end else begin
               wr_en = 1'b1;
               if (tail_ff[add_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
                  tail_in[add_q] = '0;
               end else begin
                  tail_in[add_q] = tail_ff[add_q] + 1'b1;
               end
               fill_in[add_q] = fill_ff[add_q] + 1'b1;
               if (to_exp) begin
                  exp_in = exp_ff + 1'b1;
               end else begin
                  act_in = act_ff + 1'b1;
               end
               res_status_in = mpq_pkg::STATUS_ADDED;
            end
         end else begin
            sel_in = sel_take;
            act_in = act_sw;
            exp_in = exp_sw;
            if (found) begin
               rd_en = 1'b1;
               if (head_ff[take_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
                  head_in[take_q] = '0;
               end else begin
                  head_in[take_q] = head_ff[take_q] + 1'b1;
               end
               fill_in[take_q] = fill_ff[take_q] - 1'b1;
               if (act_sw != '0) begin
                  act_in = act_sw - 1'b1;
               end
               res_level_in  = hit_lvl;
               res_status_in = mpq_pkg::STATUS_DISPATCHED;
            end else begin
               res_status_in = mpq_pkg::STATUS_EMPTY;
            end
         end
         res_waiting_in = act_in;
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         sel_ff <= 1'b0;
         act_ff <= '0;
         exp_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         sel_ff  <= sel_in;
         act_ff  <= act_in;
         exp_ff  <= exp_in;
      end
   end

   // Pending result and output register.
   always_ff @(posedge clock) begin
      res_status_ff  <= res_status_in;
      res_level_ff   <= res_level_in;
      res_waiting_ff <= res_waiting_in;
      if (cmd.load) begin
         rsp_status_ff         <= res_status_ff;
         rsp_next_level_ff     <= mpq_pkg::LEVEL_W'(res_level_ff);
         rsp_active_waiting_ff <= mpq_pkg::WAITING_W'(res_waiting_ff);
         if (res_status_ff == mpq_pkg::STATUS_DISPATCHED) begin
            rsp_next_task_ff <= mpq_pkg::TASK_ID_W'(rd_data_ff);
         end else begin
            rsp_next_task_ff <= '0;
         end
      end
   end

   // Task memory: one write or one registered read per item.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= task_mem[rd_addr];
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_next_task      = rsp_next_task_ff;
   assign rsp_next_level     = rsp_next_level_ff;
   assign rsp_active_waiting = rsp_active_waiting_ff;

endmodule

`default_nettype wire

### hw/rtl/multilevel_priority_run_queue_core.sv
// Multilevel priority run queue with active and expired banks of per-level FIFOs.
// The result of an input transfer is registered as a pending result, then loaded into
// the output register once the output slot is free; no new input is taken until then,
// owing to the pointer update and the registered read of the single task memory;
// a held result stalls the next input.
// Reset: synchronous; clears pointers, fill counts, bank select and totals.
// The task memory is not cleared.
`default_nettype none

module multilevel_priority_run_queue_core #(
   parameter int LEVELS      = mpq_pkg::LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_BITS   = mpq_pkg::TASK_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_operation,
   input  wire logic [mpq_pkg::TASK_ID_W-1:0]    req_task_id,
   input  wire logic [mpq_pkg::LEVEL_W-1:0]      req_level,
   input  wire logic                             req_from_preemption,
   input  wire logic                             req_priority_wrapped,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [mpq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [mpq_pkg::TASK_ID_W-1:0]         rsp_next_task,
   output logic [mpq_pkg::LEVEL_W-1:0]           rsp_next_level,
   output logic [mpq_pkg::WAITING_W-1:0]         rsp_active_waiting
);

   mpq_pkg::mpq_cmd_type cmd;

   // Sequencing of transfers.
   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Queue storage and result formation.
   mpq_dp #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TASK_BITS   (TASK_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_operation        (req_operation),
      .req_task_id          (req_task_id),
      .req_level            (req_level),
      .req_from_preemption  (req_from_preemption),
      .req_priority_wrapped (req_priority_wrapped),
      .rsp_status           (rsp_status),
      .rsp_next_task        (rsp_next_task),
      .rsp_next_level       (rsp_next_level),
      .rsp_active_waiting   (rsp_active_waiting)
   );

endmodule

`default_nettype wire
